/* rtl/icmp_pkg.sv */
// ----------------------------------------------------------------------------
// ICMPv6 parser package
// Shared types, phase codes and field tables for the ICMPv6 header parser.
// ----------------------------------------------------------------------------
package icmp_pkg;

    localparam int unsigned MaxMessageBytes = 65535;

    // Parse phases.
    localparam logic [4:0] PH_TYPE      = 5'd0;
    localparam logic [4:0] PH_CODE      = 5'd1;
    localparam logic [4:0] PH_CSUM      = 5'd2;
    localparam logic [4:0] PH_ECHO_ID   = 5'd3;
    localparam logic [4:0] PH_ECHO_SEQ  = 5'd4;
    localparam logic [4:0] PH_NS_RES    = 5'd5;
    localparam logic [4:0] PH_NS_HI     = 5'd6;
    localparam logic [4:0] PH_NS_LO     = 5'd7;
    localparam logic [4:0] PH_NS_OPT    = 5'd8;
    localparam logic [4:0] PH_NONCE_LEN = 5'd9;
    localparam logic [4:0] PH_NONCE     = 5'd10;
    localparam logic [4:0] PH_RS_RES    = 5'd11;
    localparam logic [4:0] PH_RA_HOP    = 5'd12;
    localparam logic [4:0] PH_RA_FLAGS  = 5'd13;
    localparam logic [4:0] PH_RA_LIFE   = 5'd14;
    localparam logic [4:0] PH_RA_REACH  = 5'd15;
    localparam logic [4:0] PH_RA_RETR   = 5'd16;
    localparam logic [4:0] PH_OPT_TYPE  = 5'd17;
    localparam logic [4:0] PH_LL_LEN    = 5'd18;
    localparam logic [4:0] PH_LL_ADDR   = 5'd19;
    localparam logic [4:0] PH_MTU_LEN   = 5'd20;
    localparam logic [4:0] PH_MTU_RES   = 5'd21;
    localparam logic [4:0] PH_MTU_VAL   = 5'd22;
    localparam logic [4:0] PH_PI_LEN    = 5'd23;
    localparam logic [4:0] PH_PI_PLEN   = 5'd24;
    localparam logic [4:0] PH_PI_FLAGS  = 5'd25;
    localparam logic [4:0] PH_PI_VALID  = 5'd26;
    localparam logic [4:0] PH_PI_PREF   = 5'd27;
    localparam logic [4:0] PH_PI_RES    = 5'd28;
    localparam logic [4:0] PH_PI_HI     = 5'd29;
    localparam logic [4:0] PH_PI_LO     = 5'd30;
    localparam logic [4:0] PH_DRAIN     = 5'd31;

    localparam logic [4:0] TAG_VERDICT = 5'd31;

    // Verdict codes.
    localparam logic [2:0] V_ALLOW     = 3'd0;
    localparam logic [2:0] V_SHORT     = 3'd1;
    localparam logic [2:0] V_BAD_TYPE  = 3'd2;
    localparam logic [2:0] V_BAD_OPT   = 3'd3;
    localparam logic [2:0] V_BAD_LL    = 3'd4;
    localparam logic [2:0] V_BAD_MTU   = 3'd5;
    localparam logic [2:0] V_BAD_PI    = 3'd6;
    localparam logic [2:0] V_TRUNC     = 3'd7;

    typedef struct packed {
        logic [7:0] msg_byte;
        logic       last_byte;
    } t_in_word;

    typedef struct packed {
        logic [4:0]  field_tag;
        logic [63:0] field_value;
        logic [2:0]  verdict;
        logic        message_done;
    } t_out_word;

    // Classified byte handed from the front part to the back part.
    typedef struct packed {
        logic        emit_field;
        logic [4:0]  tag;
        logic [63:0] value;
        logic        emit_verdict;
        logic [2:0]  verdict;
        logic [2:0]  seen;
    } t_job;

    // Byte count of each phase's field.
    function automatic logic [3:0] phase_width(input logic [4:0] ph);
        case (ph)
            PH_CSUM, PH_ECHO_ID, PH_ECHO_SEQ, PH_RA_LIFE, PH_MTU_RES: return 4'd2;
            PH_NS_RES, PH_RS_RES, PH_RA_REACH, PH_RA_RETR, PH_MTU_VAL,
            PH_PI_VALID, PH_PI_PREF, PH_PI_RES:                       return 4'd4;
            PH_NS_HI, PH_NS_LO, PH_PI_HI, PH_PI_LO:                   return 4'd8;
            PH_LL_ADDR:                                               return 4'd6;
            default:                                                  return 4'd1;
        endcase
    endfunction

    // Output tag of each phase.
    function automatic logic [4:0] phase_tag(input logic [4:0] ph);
        if (ph <= PH_RA_RETR) begin
            return ph;
        end else if (ph == PH_OPT_TYPE || ph == PH_DRAIN) begin
            return 5'd0;
        end else begin
            return ph - 5'd1;
        end
    endfunction

endpackage

/* rtl/icmp_front.sv */
// ----------------------------------------------------------------------------
// ICMPv6 parser front end
// Accepts message bytes, tracks the parse state and classifies each byte
// into at most one field word and one verdict word.
// ----------------------------------------------------------------------------
module icmp_front import icmp_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_stall,
    input  t_in_word i_data,
    output logic     o_job_valid,
    input  logic     i_job_stall,
    output t_job     o_job
);

    logic [15:0] r_pos, n_pos;
    logic [4:0]  r_phase, n_phase;
    logic [63:0] r_acc, n_acc;
    logic [3:0]  r_left, n_left;
    logic [7:0]  r_nonce, n_nonce;
    logic [7:0]  r_mtype, n_mtype;
    logic [2:0]  r_seen, n_seen;
    logic [2:0]  r_vcode, n_vcode;
    logic        r_err, n_err;
    logic        accept;
    logic [63:0] v;
    logic [3:0]  left_dec;
    logic [7:0]  b;
    t_job        job;

    assign o_stall     = i_job_stall;
    assign accept      = i_valid && !i_job_stall;
    assign o_job_valid = i_valid;
    assign o_job       = job;
    assign b           = i_data.msg_byte;
    assign v           = {r_acc[55:0], b};
    assign left_dec    = (r_left != 4'd0) ? r_left - 4'd1 : 4'd0;

    // Next state and classified word for the byte on the input.
    always_comb begin
        n_pos   = (r_pos < 16'(MaxMessageBytes)) ? r_pos + 16'd1 : r_pos;
        n_phase = r_phase;
        n_acc   = r_acc;
        n_left  = r_left;
        n_nonce = r_nonce;
        n_mtype = r_mtype;
        n_seen  = r_seen;
        n_vcode = r_vcode;
        n_err   = r_err;
        job     = '0;
        job.tag = phase_tag(r_phase);

        if (!r_err && r_phase != PH_DRAIN) begin
            n_acc  = v;
            n_left = left_dec;
            if (left_dec == 4'd0) begin
                n_acc = '0;
                case (r_phase)
                    PH_TYPE: begin
                        job.emit_field = 1'b1;
                        job.value      = v;
                        n_mtype        = b;
                        n_phase        = PH_CODE;
                    end
                    PH_CSUM: begin
                        job.emit_field = 1'b1;
                        job.value      = v;
                        if (r_mtype == 8'd128 || r_mtype == 8'd129) begin
                            n_phase = PH_ECHO_ID;
                        end else if (r_mtype == 8'd135) begin
                            n_phase = PH_NS_RES;
                        end else if (r_mtype == 8'd133) begin
                            n_phase = PH_RS_RES;
                        end else if (r_mtype == 8'd134) begin
                            n_phase = PH_RA_HOP;
                        end else begin
                            n_vcode = V_BAD_TYPE;
                            n_err   = 1'b1;
                            n_phase = PH_DRAIN;
                        end
                    end
                    PH_NS_OPT: begin
                        if (v == 64'h0e) begin
                            job.emit_field = 1'b1;
                            job.value      = v;
                            n_phase        = PH_NONCE_LEN;
                        end else begin
                            n_phase = PH_DRAIN;
                        end
                    end
                    PH_NONCE_LEN: begin
                        job.emit_field = 1'b1;
                        job.value      = v;
                        n_nonce        = b;
                        n_phase        = (b != 8'd0) ? PH_NONCE : PH_DRAIN;
                    end
                    PH_NONCE: begin
                        job.emit_field = 1'b1;
                        job.value      = v;
                        n_nonce        = r_nonce - 8'd1;
                        n_phase        = (n_nonce != 8'd0) ? PH_NONCE : PH_DRAIN;
                    end
                    PH_RA_FLAGS: begin
                        job.emit_field = 1'b1;
                        job.value      = {57'd0, b[7], b[6], b[5], b[4:3], b[2], b[1]};
                        n_phase        = PH_RA_LIFE;
                    end
                    PH_OPT_TYPE: begin
                        if (b == 8'd1) begin
                            n_seen[0] = 1'b1;
                            n_phase   = PH_LL_LEN;
                        end else if (b == 8'd5) begin
                            n_seen[1] = 1'b1;
                            n_phase   = PH_MTU_LEN;
                        end else if (b == 8'd3) begin
                            n_seen[2] = 1'b1;
                            n_phase   = PH_PI_LEN;
                        end else begin
                            n_vcode = V_BAD_OPT;
                            n_err   = 1'b1;
                            n_phase = PH_DRAIN;
                        end
                    end
                    PH_LL_LEN, PH_MTU_LEN: begin
                        if (b != 8'd1) begin
                            n_vcode = (r_phase == PH_LL_LEN) ? V_BAD_LL : V_BAD_MTU;
                            n_err   = 1'b1;
                            n_phase = PH_DRAIN;
                        end else begin
                            job.emit_field = 1'b1;
                            job.value      = 64'd8;
                            n_phase        = r_phase + 5'd1;
                        end
                    end
                    PH_PI_LEN: begin
                        if (b != 8'd4) begin
                            n_vcode = V_BAD_PI;
                            n_err   = 1'b1;
                            n_phase = PH_DRAIN;
                        end else begin
                            job.emit_field = 1'b1;
                            job.value      = 64'd32;
                            n_phase        = PH_PI_PLEN;
                        end
                    end
                    PH_PI_FLAGS: begin
                        job.emit_field = 1'b1;
                        job.value      = {61'd0, b[7], b[6], b[5]};
                        n_phase        = PH_PI_VALID;
                    end
                    default: begin
                        job.emit_field = 1'b1;
                        job.value      = v;
                        if (r_phase == PH_ECHO_SEQ || r_phase == PH_RS_RES) begin
                            n_phase = PH_DRAIN;
                        end else if (r_phase == PH_NS_LO) begin
                            n_phase = PH_NS_OPT;
                        end else if (r_phase == PH_RA_RETR || r_phase == PH_LL_ADDR ||
                                     r_phase == PH_MTU_VAL || r_phase == PH_PI_LO) begin
                            n_phase = PH_OPT_TYPE;
                        end else begin
                            n_phase = r_phase + 5'd1;
                        end
                    end
                endcase
                n_left = phase_width(n_phase);
            end
        end

        // Verdict at message end, judged on the state after this byte.
        job.seen = n_seen;
        if (i_data.last_byte) begin
            job.emit_verdict = 1'b1;
            if (n_pos < 16'd8) begin
                job.verdict = V_SHORT;
            end else if (n_err) begin
                job.verdict = n_vcode;
            end else if (n_phase == PH_DRAIN || n_phase == PH_NS_OPT ||
                         n_phase == PH_OPT_TYPE) begin
                job.verdict = V_ALLOW;
            end else begin
                job.verdict = V_TRUNC;
            end
        end
    end

    // Parse state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (accept && i_data.last_byte)) begin
            r_pos   <= '0;
            r_phase <= PH_TYPE;
            r_acc   <= '0;
            r_left  <= 4'd1;
            r_nonce <= '0;
            r_mtype <= '0;
            r_seen  <= '0;
            r_vcode <= V_ALLOW;
            r_err   <= 1'b0;
        end else if (accept) begin
            r_pos   <= n_pos;
            r_phase <= n_phase;
            r_acc   <= n_acc;
            r_left  <= n_left;
            r_nonce <= n_nonce;
            r_mtype <= n_mtype;
            r_seen  <= n_seen;
            r_vcode <= n_vcode;
            r_err   <= n_err;
        end
    end

endmodule

/* rtl/icmp_back.sv */
// ----------------------------------------------------------------------------
// ICMPv6 parser back end
// Two-entry queue of classified words, and an output stage that sends the
// field word and then the verdict word of each entry.
// ----------------------------------------------------------------------------
module icmp_back import icmp_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_job_valid,
    output logic      o_job_stall,
    input  t_job      i_job,
    output logic      o_valid,
    input  logic      i_stall,
    output t_out_word o_data
);

    t_job        r_q [2];
    logic        r_wp, r_rp;
    logic [1:0]  r_cnt;
    logic        r_half;     // field word of the head entry already sent
    logic        push, pop, head_has, send_verdict;
    t_job        head;

    assign head     = r_q[r_rp];
    assign head_has = r_cnt != 2'd0;
    assign o_job_stall = r_cnt == 2'd2;
    assign push     = i_job_valid && !o_job_stall;

    // Entries with nothing to send are dropped from the queue at once.
    assign send_verdict = r_half || !head.emit_field;
    assign o_valid  = head_has && (head.emit_field || head.emit_verdict);
    assign pop      = head_has && (!o_valid ||
                      (!i_stall && (send_verdict || !head.emit_verdict)));

    always_comb begin
        o_data = '0;
        if (send_verdict) begin
            o_data.field_tag    = TAG_VERDICT;
            o_data.field_value  = {61'd0, head.seen};
            o_data.verdict      = head.verdict;
            o_data.message_done = 1'b1;
        end else begin
            o_data.field_tag   = head.tag;
            o_data.field_value = head.value;
        end
    end

    // Queue storage.
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= i_job;
        end
    end

    // Queue pointers and output sequencing.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp   <= 1'b0;
            r_rp   <= 1'b0;
            r_cnt  <= '0;
            r_half <= 1'b0;
        end else begin
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
            if (pop) begin
                r_half <= 1'b0;
            end else if (o_valid && !i_stall) begin
                r_half <= 1'b1;
            end
        end
    end

endmodule

/* rtl/icmpv6_header_parser_top.sv */
// ----------------------------------------------------------------------------
// ICMPv6 header parser
// Byte-wide ICMPv6 message parser emitting tagged fields and a verdict.
// ----------------------------------------------------------------------------
// One message byte is accepted every cycle while the input is not stalled.
// The front end classifies each byte in the cycle it arrives; a two-entry
// queue feeds the output stage, which sends one word per cycle while the
// receiver does not stall. A byte that completes a field and ends the
// message yields two words, so the queue fills and the input is stalled
// shortly afterwards. The input is also stalled whenever a stalled output
// leaves the queue full; each classified byte is registered in the queue.
module icmpv6_header_parser_top import icmp_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_stall,
    input  t_in_word  i_data,
    output logic      o_valid,
    input  logic      i_stall,
    output t_out_word o_data
);

    logic job_valid, job_stall;
    t_job job;

    icmp_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_data      (i_data),
        .o_job_valid (job_valid),
        .i_job_stall (job_stall),
        .o_job       (job)
    );

    icmp_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (job_valid),
        .o_job_stall (job_stall),
        .i_job       (job),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_data      (o_data)
    );

endmodule

/* rtl/icmp_checker.sv */
// ----------------------------------------------------------------------------
// ICMPv6 parser port checker
// Checks the output words seen on the top level's ports.
// ----------------------------------------------------------------------------
module icmp_checker import icmp_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      o_valid,
    input logic      i_stall,
    input t_out_word o_data
);

    // A stalled word holds.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_data))
        else $error("stalled word changed");

    // Only the verdict word closes a message.
    a_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.message_done |-> o_data.field_tag == TAG_VERDICT)
        else $error("message end without verdict tag");

    // Field words carry no verdict.
    a_fverd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_data.message_done |-> o_data.verdict == V_ALLOW)
        else $error("verdict on field word");

    // The verdict word carries only the options-seen flags.
    a_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.message_done |-> o_data.field_value[63:3] == 61'd0)
        else $error("verdict value out of range");

endmodule

bind icmpv6_header_parser_top icmp_checker u_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .o_valid (o_valid),
    .i_stall (i_stall),
    .o_data  (o_data)
);

/* tb/sv/icmpv6_header_parser_top_test.sv */
// ----------------------------------------------------------------------------
// ICMPv6 header parser testbench
// Drives whole ICMPv6 messages byte by byte, predicts every field word and
// verdict word in step with each accepted byte, and checks the block's output.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module icmpv6_header_parser_top_test;
    import icmp_pkg::*;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_valid;
    logic      o_stall;
    t_in_word  i_data;
    logic      o_valid;
    logic      i_stall;
    t_out_word o_data;

    icmpv6_header_parser_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_data  (o_data)
    );

    // Parser state kept by the predictor.
    logic [15:0] pos_q;
    logic [4:0]  phase_q;
    logic [63:0] acc_q;
    logic [3:0]  left_q;
    logic [7:0]  nonce_q;
    logic [7:0]  mtype_q;
    logic [2:0]  seen_q;
    logic [2:0]  code_q;
    logic        err_q;

    t_out_word expected_words[$];
    int        error_count;
    int        byte_count;
    int        message_count;
    int        word_count;
    bit        stall_enable;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #200ms;
        $display("simulation failed");
        $finish;
    end

    function automatic logic [3:0] width_of(input logic [4:0] ph);
        case (ph)
            PH_CSUM, PH_ECHO_ID, PH_ECHO_SEQ, PH_RA_LIFE, PH_MTU_RES: return 4'd2;
            PH_NS_RES, PH_RS_RES, PH_RA_REACH, PH_RA_RETR, PH_MTU_VAL,
            PH_PI_VALID, PH_PI_PREF, PH_PI_RES: return 4'd4;
            PH_NS_HI, PH_NS_LO, PH_PI_HI, PH_PI_LO: return 4'd8;
            PH_LL_ADDR: return 4'd6;
            default: return 4'd1;
        endcase
    endfunction

    function automatic logic [4:0] tag_of(input logic [4:0] ph);
        if (ph <= PH_RA_RETR) return ph;
        if (ph == PH_OPT_TYPE || ph == PH_DRAIN) return 5'd0;
        return ph - 5'd1;
    endfunction

    task automatic parser_reset();
        pos_q   = '0;
        acc_q   = '0;
        nonce_q = '0;
        mtype_q = '0;
        seen_q  = '0;
        code_q  = V_ALLOW;
        err_q   = 1'b0;
        goto_phase(PH_TYPE);
    endtask

    task automatic goto_phase(input logic [4:0] ph);
        phase_q = ph;
        left_q  = width_of(ph);
    endtask

    task automatic push_field(input logic [4:0] tag, input logic [63:0] v);
        t_out_word w;
        w.field_tag    = tag;
        w.field_value  = v;
        w.verdict      = V_ALLOW;
        w.message_done = 1'b0;
        expected_words.push_back(w);
    endtask

    task automatic latch_error(input logic [2:0] c);
        code_q = c;
        err_q  = 1'b1;
        goto_phase(PH_DRAIN);
    endtask

    // Act on a completed field according to the current phase.
    task automatic complete_field(input logic [63:0] v);
        logic [4:0] ph;
        ph = phase_q;
        case (ph)
            PH_TYPE: begin
                push_field(tag_of(ph), v);
                mtype_q = v[7:0];
                goto_phase(PH_CODE);
            end
            PH_CSUM: begin
                push_field(tag_of(ph), v);
                if (mtype_q == 8'd128 || mtype_q == 8'd129) goto_phase(PH_ECHO_ID);
                else if (mtype_q == 8'd135) goto_phase(PH_NS_RES);
                else if (mtype_q == 8'd133) goto_phase(PH_RS_RES);
                else if (mtype_q == 8'd134) goto_phase(PH_RA_HOP);
                else latch_error(V_BAD_TYPE);
            end
            PH_NS_OPT: begin
                if (v == 64'h0e) begin
                    push_field(tag_of(ph), v);
                    goto_phase(PH_NONCE_LEN);
                end else begin
                    goto_phase(PH_DRAIN);
                end
            end
            PH_NONCE_LEN: begin
                push_field(tag_of(ph), v);
                nonce_q = v[7:0];
                goto_phase(nonce_q != 0 ? PH_NONCE : PH_DRAIN);
            end
            PH_NONCE: begin
                push_field(tag_of(ph), v);
                nonce_q = nonce_q - 8'd1;
                goto_phase(nonce_q != 0 ? PH_NONCE : PH_DRAIN);
            end
            PH_RA_FLAGS: begin
                push_field(tag_of(ph), {57'd0, v[7], v[6], v[5], v[4:3], v[2], v[1]});
                goto_phase(PH_RA_LIFE);
            end
            PH_OPT_TYPE: begin
                if (v == 64'd1) begin
                    seen_q[0] = 1'b1;
                    goto_phase(PH_LL_LEN);
                end else if (v == 64'd5) begin
                    seen_q[1] = 1'b1;
                    goto_phase(PH_MTU_LEN);
                end else if (v == 64'd3) begin
                    seen_q[2] = 1'b1;
                    goto_phase(PH_PI_LEN);
                end else begin
                    latch_error(V_BAD_OPT);
                end
            end
            PH_LL_LEN: begin
                if (v != 64'd1) latch_error(V_BAD_LL);
                else begin
                    push_field(tag_of(ph), 64'd8);
                    goto_phase(PH_LL_ADDR);
                end
            end
            PH_MTU_LEN: begin
                if (v != 64'd1) latch_error(V_BAD_MTU);
                else begin
                    push_field(tag_of(ph), 64'd8);
                    goto_phase(PH_MTU_RES);
                end
            end
            PH_PI_LEN: begin
                if (v != 64'd4) latch_error(V_BAD_PI);
                else begin
                    push_field(tag_of(ph), 64'd32);
                    goto_phase(PH_PI_PLEN);
                end
            end
            PH_PI_FLAGS: begin
                push_field(tag_of(ph), {61'd0, v[7], v[6], v[5]});
                goto_phase(PH_PI_VALID);
            end
            PH_DRAIN: ;
            default: begin
                push_field(tag_of(ph), v);
                if (ph == PH_ECHO_SEQ || ph == PH_RS_RES) goto_phase(PH_DRAIN);
                else if (ph == PH_NS_LO) goto_phase(PH_NS_OPT);
                else if (ph == PH_RA_RETR || ph == PH_LL_ADDR || ph == PH_MTU_VAL ||
                         ph == PH_PI_LO) goto_phase(PH_OPT_TYPE);
                else goto_phase(ph + 5'd1);
            end
        endcase
    endtask

    // Predict the words caused by one accepted byte.
    task automatic predict_byte(input t_in_word w);
        t_out_word v;
        logic [63:0] f;
        if (pos_q != 16'hffff) pos_q = pos_q + 16'd1;
        if (!err_q && phase_q != PH_DRAIN) begin
            acc_q = {acc_q[55:0], w.msg_byte};
            if (left_q != 0) left_q = left_q - 4'd1;
            if (left_q == 0) begin
                f = acc_q;
                acc_q = '0;
                complete_field(f);
            end
        end
        if (w.last_byte) begin
            v.field_tag    = TAG_VERDICT;
            v.field_value  = {61'd0, seen_q};
            v.message_done = 1'b1;
            if (pos_q < 16'd8) v.verdict = V_SHORT;
            else if (err_q) v.verdict = code_q;
            else if (phase_q == PH_DRAIN || phase_q == PH_NS_OPT ||
                     phase_q == PH_OPT_TYPE) v.verdict = V_ALLOW;
            else v.verdict = V_TRUNC;
            expected_words.push_back(v);
            parser_reset();
            message_count++;
        end
    endtask

    // Send one byte, with a random gap before it. Valid stays high after the
    // accepting edge so that back-to-back bytes need only one assignment.
    task automatic send_byte(input logic [7:0] b, input bit last);
        int gap;
        t_in_word w;
        gap = (stall_enable && $urandom_range(0, 3) == 0) ? $urandom_range(0, 12) : 0;
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        w.msg_byte  = b;
        w.last_byte = last;
        i_data  <= w;
        i_valid <= 1'b1;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        predict_byte(w);
        byte_count++;
    endtask

    task automatic send_message(input logic [7:0] m[$]);
        foreach (m[k]) send_byte(m[k], k == m.size() - 1);
    endtask

    task automatic add_bytes(ref logic [7:0] m[$], input int n, input bit rnd,
                             input logic [7:0] fill);
        repeat (n) m.push_back(rnd ? 8'($urandom) : fill);
    endtask

    // Random RA option body of the given option type.
    task automatic add_option(ref logic [7:0] m[$], input int kind, input bit good);
        case (kind)
            0: begin
                m.push_back(8'd1);
                m.push_back(good ? 8'd1 : 8'($urandom_range(2, 255)));
                add_bytes(m, 6, 1, 0);
            end
            1: begin
                m.push_back(8'd5);
                m.push_back(good ? 8'd1 : 8'd0);
                add_bytes(m, 6, 1, 0);
            end
            2: begin
                m.push_back(8'd3);
                m.push_back(good ? 8'd4 : 8'($urandom_range(5, 255)));
                add_bytes(m, 30, 1, 0);
            end
            default: begin
                m.push_back(8'($urandom_range(6, 255)));
                add_bytes(m, 7, 1, 0);
            end
        endcase
    endtask

    // Build a random message, mostly well formed.
    task automatic build_message(ref logic [7:0] m[$]);
        int kind;
        int cut;
        m.delete();
        kind = $urandom_range(0, 9);
        case (kind)
            0: m.push_back(8'd128);
            1: m.push_back(8'd129);
            2, 3: m.push_back(8'd135);
            4: m.push_back(8'd133);
            5, 6, 7, 8: m.push_back(8'd134);
            default: m.push_back(8'($urandom));
        endcase
        add_bytes(m, 3, 1, 0);
        case (m[0])
            8'd128, 8'd129: add_bytes(m, $urandom_range(4, 8), 1, 0);
            8'd133: add_bytes(m, $urandom_range(4, 6), 1, 0);
            8'd135: begin
                add_bytes(m, 20, 1, 0);
                if ($urandom_range(0, 3) != 0) begin
                    m.push_back(8'h0e);
                    m.push_back(8'($urandom_range(0, 6)));
                    add_bytes(m, m[m.size() - 1], 1, 0);
                end else begin
                    add_bytes(m, $urandom_range(0, 3), 1, 0);
                end
            end
            8'd134: begin
                add_bytes(m, 12, 1, 0);
                repeat ($urandom_range(0, 3))
                    add_option(m, $urandom_range(0, 3), $urandom_range(0, 7) != 0);
            end
            default: add_bytes(m, $urandom_range(4, 10), 1, 0);
        endcase
        // Now and then cut the message short.
        if ($urandom_range(0, 7) == 0) begin
            cut = $urandom_range(1, m.size());
            while (m.size() > cut) void'(m.pop_back());
        end
    endtask

    // Compare each accepted output word with the oldest prediction.
    always @(posedge i_clk) begin
        t_out_word e;
        if (i_rst_n && o_valid && !i_stall) begin
            word_count++;
            if (expected_words.size() == 0) begin
                $error("unexpected word tag %0d", o_data.field_tag);
                error_count++;
            end else begin
                e = expected_words.pop_front();
                if (o_data.field_tag !== e.field_tag) begin
                    $error("field_tag expected %0d actual %0d", e.field_tag,
                           o_data.field_tag);
                    error_count++;
                end
                if (o_data.field_value !== e.field_value) begin
                    $error("field_value expected %h actual %h", e.field_value,
                           o_data.field_value);
                    error_count++;
                end
                if (o_data.verdict !== e.verdict) begin
                    $error("verdict expected %0d actual %0d", e.verdict, o_data.verdict);
                    error_count++;
                end
                if (o_data.message_done !== e.message_done) begin
                    $error("message_done expected %0d actual %0d", e.message_done,
                           o_data.message_done);
                    error_count++;
                end
            end
        end
    end

    // Receiver stall: random holds per word, or none.
    initial begin
        int hold;
        i_stall = 1'b0;
        forever begin
            @(posedge i_clk);
            if (stall_enable && $urandom_range(0, 3) == 0) begin
                hold = $urandom_range(0, 12);
                if (hold != 0) begin
                    i_stall <= 1'b1;
                    repeat (hold) @(posedge i_clk);
                    i_stall <= 1'b0;
                end
            end
        end
    end

    task automatic wait_drained();
        i_valid <= 1'b0;
        while (expected_words.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Directed messages: every type, both extremes and each special case.
    task automatic test_directed();
        logic [7:0] m[$];
        m = '{8'd128, 8'h00, 8'hff, 8'hff, 8'h12, 8'h34, 8'hff, 8'h00};
        send_message(m);
        m = '{8'd129, 8'hff, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h01, 8'haa};
        send_message(m);
        // Too short, also a one-byte message.
        m = '{8'd128, 8'h00, 8'h00};
        send_message(m);
        m = '{8'hff};
        send_message(m);
        // Unsupported type.
        m = '{8'd200, 8'h00, 8'h00, 8'h00, 8'h01, 8'h02, 8'h03, 8'h04};
        send_message(m);
        // Router solicitation.
        m = '{8'd133, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
        send_message(m);
        // NS with nonce of two bytes, with zero-length nonce, with a non-nonce option.
        m.delete();
        m.push_back(8'd135); add_bytes(m, 23, 1, 0);
        m.push_back(8'h0e); m.push_back(8'd2); m.push_back(8'h55); m.push_back(8'haa);
        send_message(m);
        m.delete();
        m.push_back(8'd135); add_bytes(m, 23, 0, 8'hff);
        m.push_back(8'h0e); m.push_back(8'd0);
        send_message(m);
        m.delete();
        m.push_back(8'd135); add_bytes(m, 23, 0, 8'h00); m.push_back(8'h01);
        send_message(m);
        // Truncated nonce.
        m.delete();
        m.push_back(8'd135); add_bytes(m, 23, 1, 0);
        m.push_back(8'h0e); m.push_back(8'd5); m.push_back(8'h01);
        send_message(m);
        // RA with all flags set and every option.
        m.delete();
        m.push_back(8'd134); add_bytes(m, 3, 1, 0);
        m.push_back(8'd64); m.push_back(8'hff); add_bytes(m, 10, 0, 8'hff);
        add_option(m, 0, 1); add_option(m, 1, 1); add_option(m, 2, 1);
        send_message(m);
        // RA with flags clear and no options.
        m.delete();
        m.push_back(8'd134); add_bytes(m, 15, 0, 8'h00);
        send_message(m);
        // Bad option, bad lengths.
        for (int k = 0; k < 3; k++) begin
            m.delete();
            m.push_back(8'd134); add_bytes(m, 15, 1, 0);
            add_option(m, k, 0);
            send_message(m);
        end
        m.delete();
        m.push_back(8'd134); add_bytes(m, 15, 1, 0); add_option(m, 3, 1);
        send_message(m);
        // Truncated inside a field and inside an option.
        m.delete();
        m.push_back(8'd135); add_bytes(m, 11, 1, 0);
        send_message(m);
        m = '{8'd134, 8'h00, 8'h00, 8'h00, 8'h40, 8'h18, 8'h00, 8'h00, 8'h01};
        send_message(m);
        m.delete();
        m.push_back(8'd134); add_bytes(m, 15, 1, 0); m.push_back(8'd3); m.push_back(8'd4);
        add_bytes(m, 10, 1, 0);
        send_message(m);
        wait_drained();
    endtask

    // Random messages with random idling on both sides.
    task automatic test_random();
        logic [7:0] m[$];
        int n;
        n = 0;
        stall_enable = 1'b1;
        while (byte_count < 920) begin
            build_message(m);
            send_message(m);
            n++;
            // Hold off once until every predicted word has come out.
            if (n == 10) wait_drained();
            if (n == 20) stall_enable = 1'b0;
            if (n == 30) stall_enable = 1'b1;
        end
        wait_drained();
    endtask

    // A long router solicitation with a long run of trailing bytes.
    task automatic test_long_message();
        logic [7:0] m[$];
        stall_enable = 1'b0;
        m.delete();
        m.push_back(8'd133); add_bytes(m, 7, 1, 0);
        foreach (m[k]) send_byte(m[k], 1'b0);
        repeat (60) send_byte(8'($urandom), 1'b0);
        send_byte(8'h00, 1'b1);
        wait_drained();
    endtask

    initial begin
        i_rst_n      = 1'b0;
        i_valid      = 1'b0;
        i_data       = '0;
        stall_enable = 1'b0;
        error_count  = 0;
        byte_count   = 0;
        message_count = 0;
        word_count   = 0;
        parser_reset();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random();
        test_long_message();
        repeat (20) @(posedge i_clk);
        $display("Sent %0d bytes in %0d messages, checked %0d words.", byte_count,
                 message_count, word_count);
        $display("Covered echo, NS, RS, RA options, errors, truncation and long runs.");
        if (error_count == 0 && expected_words.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
